### design/twls_pkg.sv
// twls_pkg: shared constants, codes and controller/datapath signal groups
// for the two-level weighted sampler; no dependencies
`default_nettype none

package twls_pkg;

  localparam int DEF_MAX_ROWS    = 16;
  localparam int DEF_MAX_COLS    = 256;
  localparam int DEF_WEIGHT_BITS = 16;
  localparam int FILL_WEIGHT     = 100;

  localparam int KIND_W     = 2;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 8;
  localparam int VALUE_W    = 16;
  localparam int FRAC_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int WEIGHT_W   = 16;
  localparam int TOTAL_W    = 36;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INC    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEC    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SET    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  typedef struct packed {
    logic load;
    logic clear;
    logic mul_step;
    logic row_start;
    logic row_step;
    logic col_start;
    logic col_step;
    logic upd_wr;
    logic res_pick;
    logic res_fail;
    logic res_oor;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic refill;
    logic clr_last;
    logic is_sample;
    logic mul_last;
    logic row_hit;
    logic row_last;
    logic col_hit;
    logic col_last;
    logic oor;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

### design/twls_ram.sv
// twls_ram: generic simple dual-port ram, one write and one registered read
// per cycle; no dependencies
`default_nettype none

module twls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### design/twls_dp.sv
// twls_dp: sampler datapath - size registers, row totals, grand total, scaling
// multiplier, row and column scans, weight ram and result register
// depends on twls_pkg and twls_ram
`default_nettype none

module twls_dp #(
  parameter int MAX_ROWS    = twls_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = twls_pkg::DEF_MAX_COLS,
  parameter int WEIGHT_BITS = twls_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [twls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [twls_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [twls_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [twls_pkg::ROW_W-1:0]      in_row,
  input  wire logic [twls_pkg::COL_W-1:0]      in_col,
  input  wire logic [twls_pkg::VALUE_W-1:0]    in_value,
  input  wire logic [twls_pkg::FRAC_W-1:0]     in_frac,
  input  wire twls_pkg::dp_cmd_t               cmd,
  output twls_pkg::dp_stat_t                   stat,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic      [twls_pkg::STATUS_W-1:0]   out_status,
  output logic      [twls_pkg::ROW_W-1:0]      out_row,
  output logic      [twls_pkg::COL_W-1:0]      out_col,
  output logic      [twls_pkg::WEIGHT_W-1:0]   out_weight,
  output logic      [twls_pkg::TOTAL_W-1:0]    out_total
);

  import twls_pkg::*;

  localparam int WB        = WEIGHT_BITS;
  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RN_W      = $clog2(MAX_ROWS + 1);
  localparam int CN_W      = $clog2(MAX_COLS + 1);
  localparam int AW        = RW + CW;
  localparam int DEPTH     = 2 ** AW;
  localparam int RT_W      = WB + CW;
  localparam int GT_W      = RT_W + RW;
  localparam int MUL_STEPS = (GT_W + 15) / 16;
  localparam int PAD_W     = MUL_STEPS * 16;
  localparam int ACC_W     = FRAC_W + PAD_W;
  localparam int PROD_W    = FRAC_W + 16;
  localparam int MC_W      = $clog2(MUL_STEPS + 1);
  localparam int ROWS_RST  = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int COLS_RST  = (MAX_COLS < 256) ? MAX_COLS : 256;

  // sizes
  logic [RN_W-1:0] rows_r, rows_nxt;
  logic [CN_W-1:0] cols_r, cols_nxt;
  logic            refill;

  // item
  logic [KIND_W-1:0]  kind_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [VALUE_W-1:0] value_r;
  logic [FRAC_W-1:0]  u_r;

  // totals
  logic [RT_W-1:0] rt_r [MAX_ROWS];
  logic [GT_W-1:0] gt_r;
  logic [RT_W-1:0] fill_row;
  logic [RT_W-1:0] rt_sel;

  // clearing pass
  logic [AW-1:0] clr_cnt_r;

  // scaling
  logic [PAD_W-1:0]  tot_sh_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [MC_W-1:0]   mul_cnt_r;
  logic [GT_W-1:0]   z;

  // scans
  logic [RW-1:0]   ridx_r;
  logic [GT_W-1:0] cum_r;
  logic [GT_W-1:0] row_sum;
  logic            row_hit, row_last;
  logic [RT_W-1:0] rest_r, run_r, run_sum;
  logic [CW-1:0]   ci_r, cd_r;
  logic            col_hit, col_last;

  // weight ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, uaddr;
  logic [WB-1:0] ram_wdata, rdata;

  // update
  logic [WB-1:0] nw;
  logic          refuse, upd_ok, oor;

  // result
  logic [STATUS_W-1:0] res_status_r;
  logic [ROW_W-1:0]    res_row_r;
  logic [COL_W-1:0]    res_col_r;
  logic [WB-1:0]       res_weight_r;
  logic                out_valid_r;

  // size registers, clamped to 1..max
  assign refill = cfg_we && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS);

  always_comb begin
    logic [4:0] rv;
    logic [8:0] cv;
    rv = cfg_data[4:0];
    cv = cfg_data[8:0];
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we && cfg_index == CFG_ROWS) begin
      if (rv == 5'd0) begin
        rows_nxt = RN_W'(1);
      end else if (32'(rv) > MAX_ROWS) begin
        rows_nxt = RN_W'(MAX_ROWS);
      end else begin
        rows_nxt = RN_W'(rv);
      end
    end
    if (cfg_we && cfg_index == CFG_COLS) begin
      if (cv == 9'd0) begin
        cols_nxt = CN_W'(1);
      end else if (32'(cv) > MAX_COLS) begin
        cols_nxt = CN_W'(MAX_COLS);
      end else begin
        cols_nxt = CN_W'(cv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= RN_W'(ROWS_RST);
      cols_r    <= CN_W'(COLS_RST);
      clr_cnt_r <= '0;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      if (refill) begin
        clr_cnt_r <= '0;
      end else if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // item capture and scaling multiplier, most significant chunk first
  assign z = acc_r[FRAC_W +: GT_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      row_r     <= in_row;
      col_r     <= in_col;
      value_r   <= in_value;
      u_r       <= in_frac;
      tot_sh_r  <= PAD_W'(gt_r);
      acc_r     <= '0;
      mul_cnt_r <= '0;
    end else if (cmd.mul_step) begin
      prod_r    <= PROD_W'(u_r) * PROD_W'(tot_sh_r[PAD_W-1 -: 16]);
      tot_sh_r  <= tot_sh_r << 16;
      mul_cnt_r <= mul_cnt_r + MC_W'(1);
      if (mul_cnt_r != '0) begin
        acc_r <= (acc_r << 16) + ACC_W'(prod_r);
      end
    end
  end

  // row totals and grand total
  assign fill_row = RT_W'(FILL_WEIGHT) * RT_W'(cols_r);
  assign rt_sel   = rt_r[ridx_r];

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int i = 0; i < MAX_ROWS; i++) begin
        rt_r[i] <= fill_row;
      end
      gt_r <= GT_W'(rt_r[0]) * GT_W'(rows_r);
    end else if (upd_ok) begin
      rt_r[ridx_r] <= rt_sel - RT_W'(rdata) + RT_W'(nw);
      gt_r         <= gt_r - GT_W'(rdata) + GT_W'(nw);
    end
  end

  // row scan
  assign row_sum  = cum_r + GT_W'(rt_sel);
  assign row_hit  = row_sum > z;
  assign row_last = (32'(ridx_r) + 32'd1) == 32'(rows_r);

  // column scan, ram data trails the issued column, as the ram read is registered
  assign run_sum  = run_r + RT_W'(rdata);
  assign col_hit  = run_sum > rest_r;
  assign col_last = (32'(cd_r) + 32'd1) == 32'(cols_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ridx_r <= RW'(in_row);
    end else if (cmd.row_start) begin
      ridx_r <= '0;
    end else if (cmd.row_step && !row_hit && !row_last) begin
      ridx_r <= ridx_r + RW'(1);
    end
    if (cmd.row_start) begin
      cum_r <= '0;
    end else if (cmd.row_step && !row_hit) begin
      cum_r <= row_sum;
    end
    if (cmd.col_start) begin
      rest_r <= RT_W'(z - cum_r);
      run_r  <= '0;
      ci_r   <= CW'(1);
      cd_r   <= '0;
    end else if (cmd.col_step) begin
      ci_r <= ci_r + CW'(1);
      if (!col_hit) begin
        run_r <= run_sum;
        cd_r  <= cd_r + CW'(1);
      end
    end
  end

  // weight changes
  assign oor   = (32'(row_r) >= 32'(rows_r)) || (32'(col_r) >= 32'(cols_r));
  assign uaddr = {ridx_r, CW'(col_r)};

  always_comb begin
    refuse = 1'b0;
    nw     = rdata;
    case (kind_r)
      KIND_INC: begin
        refuse = &rdata;
        nw     = rdata + WB'(1);
      end
      KIND_DEC: begin
        refuse = (rdata == '0);
        nw     = rdata - WB'(1);
      end
      KIND_SET: begin
        refuse = |(32'(value_r) >> WB);
        nw     = WB'(value_r);
      end
      default: begin
        refuse = 1'b0;
        nw     = rdata;
      end
    endcase
  end

  assign upd_ok = cmd.upd_wr && !refuse;

  always_comb begin
    ram_raddr = uaddr;
    if (cmd.col_start) begin
      ram_raddr = {ridx_r, {CW{1'b0}}};
    end else if (cmd.col_step) begin
      ram_raddr = {ridx_r, ci_r};
    end
  end

  assign ram_we    = cmd.clear || upd_ok;
  assign ram_waddr = cmd.clear ? clr_cnt_r : uaddr;
  assign ram_wdata = cmd.clear ? WB'(FILL_WEIGHT) : nw;

  twls_ram #(
    .WIDTH (WB),
    .DEPTH (DEPTH)
  ) u_weights (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  // result and output register
  always_ff @(posedge clk) begin
    if (cmd.res_pick) begin
      res_status_r <= ST_OK;
      res_row_r    <= ROW_W'(ridx_r);
      res_col_r    <= COL_W'(cd_r);
      res_weight_r <= rdata;
    end else if (cmd.res_fail) begin
      res_status_r <= ST_EMPTY;
      res_row_r    <= '0;
      res_col_r    <= '0;
      res_weight_r <= '0;
    end else if (cmd.res_oor) begin
      res_status_r <= ST_RANGE;
      res_row_r    <= row_r;
      res_col_r    <= col_r;
      res_weight_r <= '0;
    end else if (cmd.upd_wr) begin
      res_status_r <= refuse ? ST_REFUSED : ST_OK;
      res_row_r    <= row_r;
      res_col_r    <= col_r;
      res_weight_r <= refuse ? rdata : nw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status_r;
      out_row    <= res_row_r;
      out_col    <= res_col_r;
      out_weight <= WEIGHT_W'(res_weight_r);
      out_total  <= TOTAL_W'(gt_r);
    end
  end

  assign out_valid = out_valid_r;

  assign stat.refill    = refill;
  assign stat.clr_last  = &clr_cnt_r;
  assign stat.is_sample = (kind_r == KIND_SAMPLE);
  assign stat.mul_last  = (mul_cnt_r == MC_W'(MUL_STEPS));
  assign stat.row_hit   = row_hit;
  assign stat.row_last  = row_last;
  assign stat.col_hit   = col_hit;
  assign stat.col_last  = col_last;
  assign stat.oor       = oor;
  assign stat.out_free  = !out_valid_r || out_ready;

endmodule

`default_nettype wire

### design/twls_ctrl.sv
// twls_ctrl: sequencing state machine for the sampler, drives the datapath
// through command flags and follows its status; depends on twls_pkg
`default_nettype none

module twls_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               cfg_valid,
  output logic                    in_ready,
  input  wire twls_pkg::dp_stat_t stat,
  output twls_pkg::dp_cmd_t       cmd
);

  import twls_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DISP  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_RSCAN = 4'd4;
  localparam logic [3:0] S_CSCAN = 4'd5;
  localparam logic [3:0] S_URD   = 4'd6;
  localparam logic [3:0] S_UWR   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE) && !cfg_valid;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = stat.is_sample ? S_MUL : S_URD;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (stat.mul_last) begin
          cmd.row_start = 1'b1;
          state_nxt     = S_RSCAN;
        end
      end
      S_RSCAN: begin
        cmd.row_step = 1'b1;
        if (stat.row_hit) begin
          cmd.col_start = 1'b1;
          state_nxt     = S_CSCAN;
        end else if (stat.row_last) begin
          cmd.res_fail = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_CSCAN: begin
        cmd.col_step = 1'b1;
        if (stat.col_hit) begin
          cmd.res_pick = 1'b1;
          state_nxt    = S_EMIT;
        end else if (stat.col_last) begin
          cmd.res_fail = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_URD: begin
        if (stat.oor) begin
          cmd.res_oor = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          state_nxt = S_UWR;
        end
      end
      S_UWR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // a size write refills the table
    if (stat.refill) begin
      state_nxt = S_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### design/two_level_weighted_sampler.sv
// two_level_weighted_sampler: a sample is accepted, dispatched and scaled by the grand total
// in 16-bit chunks (2 by default), then the rows and then the columns of the hit row are
// scanned one per cycle (weight ram read port) before the result is emitted; a weight change
// reads the entry and writes it back unless refused, with no write when out of range.
// one item at a time; the next item is taken while the result waits in the output register.
// reset, and every write to a size register, starts a clearing pass over all
// 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) weight ram entries (4096 by default) with in_tready low.
`default_nettype none

module two_level_weighted_sampler #(
  parameter int MAX_ROWS    = twls_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = twls_pkg::DEF_MAX_COLS,
  parameter int WEIGHT_BITS = twls_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // row [3:0], col [11:4], value [27:12], random_fraction [59:28], zero [63:60]
  input  wire logic [twls_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind [1:0]
  input  wire logic [twls_pkg::KIND_W-1:0]     in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // picked_row [3:0], picked_col [11:4], weight [27:12], total [63:28]
  output logic      [twls_pkg::OUT_DATA_W-1:0] out_tdata,
  // status [1:0]
  output logic      [twls_pkg::STATUS_W-1:0]   out_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [twls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [twls_pkg::CFG_DATA_W-1:0] cfg_data
);

  import twls_pkg::*;

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [STATUS_W-1:0]  out_status;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic [WEIGHT_W-1:0]  out_weight;
  logic [TOTAL_W-1:0]   out_total;

  assign cfg_ready = 1'b1;

  twls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .cfg_valid (cfg_valid),
    .in_ready  (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  twls_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_kind    (in_tuser),
    .in_row     (in_tdata[3:0]),
    .in_col     (in_tdata[11:4]),
    .in_value   (in_tdata[27:12]),
    .in_frac    (in_tdata[59:28]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_status),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_weight (out_weight),
    .out_total  (out_total)
  );

  assign out_tdata = {out_total, out_weight, out_col, out_row};
  assign out_tuser = out_status;

endmodule

`default_nettype wire

### sim/tb_top.sv
// tb_top: self-checking bench for two_level_weighted_sampler, a directed table then random
// phases over several table sizes, each result checked against the table's expected values or a local prediction
// depends on twls_pkg and two_level_weighted_sampler
`default_nettype none

module tb_top;
  import twls_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int PHASE_ITEMS  = 180;
  localparam logic [WEIGHT_W-1:0] WEIGHT_TOP = '1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic [FRAC_W-1:0]  frac;
  } sample_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ROW_W-1:0]    prow;
    logic [COL_W-1:0]    pcol;
    logic [WEIGHT_W-1:0] weight;
    logic [TOTAL_W-1:0]  total;
  } pick_t;

  typedef struct packed {
    logic                  is_cfg;
    logic                  typed;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    sample_req_t           req;
    pick_t                 want;
  } plan_row_t;

  bit clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [KIND_W-1:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0] out_tuser;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // local copy of the weight table
  logic [WEIGHT_W-1:0] wt [DEF_MAX_ROWS][DEF_MAX_COLS];
  logic [TOTAL_W-1:0] row_sum [DEF_MAX_ROWS];
  logic [TOTAL_W-1:0] grand_sum;
  int n_rows, n_cols;
  int hot_row, hot_col;

  pick_t pending_picks[$];
  plan_row_t plan[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit in_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  two_level_weighted_sampler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic void refill_table();
    for (int r = 0; r < DEF_MAX_ROWS; r++) begin
      for (int c = 0; c < DEF_MAX_COLS; c++) wt[r][c] = WEIGHT_W'(FILL_WEIGHT);
      row_sum[r] = TOTAL_W'(FILL_WEIGHT * n_cols);
    end
    grand_sum = TOTAL_W'(FILL_WEIGHT * n_cols * n_rows);
  endfunction

  function automatic void apply_size(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    int v;
    if (idx == CFG_ROWS) begin
      v = int'(val[4:0]);
      n_rows = (v < 1) ? 1 : (v > DEF_MAX_ROWS) ? DEF_MAX_ROWS : v;
      refill_table();
    end else if (idx == CFG_COLS) begin
      v = int'(val);
      n_cols = (v < 1) ? 1 : (v > DEF_MAX_COLS) ? DEF_MAX_COLS : v;
      refill_table();
    end
  endfunction

  // works out the result of one item and moves the local table on
  function automatic pick_t predict_pick(input sample_req_t it);
    pick_t p;
    logic [67:0] prod;
    logic [TOTAL_W-1:0] z, cum, run;
    logic [WEIGHT_W-1:0] old_w, new_w;
    int ri, ci;
    bit found;
    p.status = ST_OK;
    p.prow = it.row;
    p.pcol = it.col;
    p.weight = '0;
    if (it.kind == KIND_SAMPLE) begin
      prod = 68'(it.frac) * 68'(grand_sum);
      z = prod[67:32];
      p.prow = '0;
      p.pcol = '0;
      ri = 0;
      cum = '0;
      found = 1'b0;
      while (ri < n_rows && !found) begin
        if (cum + row_sum[ri] > z) found = 1'b1;
        else begin
          cum = cum + row_sum[ri];
          ri++;
        end
      end
      if (found) begin
        found = 1'b0;
        ci = 0;
        run = '0;
        while (ci < n_cols && !found) begin
          run = run + TOTAL_W'(wt[ri][ci]);
          if (run > z - cum) found = 1'b1;
          else ci++;
        end
      end
      if (found) begin
        p.prow = ROW_W'(ri);
        p.pcol = COL_W'(ci);
        p.weight = wt[ri][ci];
      end else begin
        p.status = ST_EMPTY;
      end
    end else if (int'(it.row) >= n_rows || int'(it.col) >= n_cols) begin
      p.status = ST_RANGE;
    end else begin
      old_w = wt[it.row][it.col];
      new_w = old_w;
      case (it.kind)
        KIND_INC: begin
          if (old_w == WEIGHT_TOP) p.status = ST_REFUSED;
          else new_w = old_w + WEIGHT_W'(1);
        end
        KIND_DEC: begin
          if (old_w == '0) p.status = ST_REFUSED;
          else new_w = old_w - WEIGHT_W'(1);
        end
        default: new_w = it.value;
      endcase
      if (p.status == ST_OK) begin
        wt[it.row][it.col] = new_w;
        row_sum[it.row] = row_sum[it.row] - TOTAL_W'(old_w) + TOTAL_W'(new_w);
        grand_sum = grand_sum - TOTAL_W'(old_w) + TOTAL_W'(new_w);
      end
      p.weight = wt[it.row][it.col];
    end
    p.total = grand_sum;
    return p;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly in-range changes, often on the same entry so refusals come up
  function automatic sample_req_t random_req();
    sample_req_t it;
    int p;
    p = $urandom_range(0, 99);
    it.kind = (p < 40) ? KIND_SAMPLE : (p < 55) ? KIND_INC : (p < 75) ? KIND_DEC : KIND_SET;
    p = $urandom_range(0, 99);
    if (p < 25) begin
      it.row = ROW_W'(hot_row);
      it.col = COL_W'(hot_col);
    end else if (p < 80) begin
      it.row = ROW_W'($urandom_range(0, n_rows - 1));
      it.col = COL_W'($urandom_range(0, n_cols - 1));
    end else begin
      it.row = ROW_W'($urandom_range(0, 15));
      it.col = COL_W'($urandom_range(0, 255));
    end
    if (it.kind != KIND_SAMPLE && $urandom_range(0, 9) == 0) begin
      hot_row = int'(it.row);
      hot_col = int'(it.col);
    end
    p = $urandom_range(0, 99);
    it.value = (p < 30) ? '0 : (p < 45) ? WEIGHT_TOP
             : VALUE_W'((p < 60) ? $urandom_range(1, 3) : $urandom_range(0, 65535));
    p = $urandom_range(0, 19);
    it.frac = (p == 0) ? 32'd0 : (p == 1) ? 32'hFFFF_FFFF : $urandom;
    return it;
  endfunction

  task automatic table_item(input logic [KIND_W-1:0] kind, input int row, input int col,
                            input int value, input logic [FRAC_W-1:0] frac);
    plan_row_t pr;
    pr = '0;
    pr.req = '{kind, row[ROW_W-1:0], col[COL_W-1:0], value[VALUE_W-1:0], frac};
    plan = {plan, pr};
  endtask

  task automatic table_checked(input logic [KIND_W-1:0] kind, input int row, input int col,
                               input int value, input logic [FRAC_W-1:0] frac,
                               input logic [STATUS_W-1:0] st, input int prow, input int pcol,
                               input int weight, input longint total);
    plan_row_t pr;
    pr = '0;
    pr.typed = 1'b1;
    pr.req = '{kind, row[ROW_W-1:0], col[COL_W-1:0], value[VALUE_W-1:0], frac};
    pr.want = '{st, prow[ROW_W-1:0], pcol[COL_W-1:0], weight[WEIGHT_W-1:0],
                total[TOTAL_W-1:0]};
    plan = {plan, pr};
  endtask

  task automatic table_size(input logic [CFG_IDX_W-1:0] idx, input int val);
    plan_row_t pr;
    pr = '0;
    pr.is_cfg = 1'b1;
    pr.cfg_idx = idx;
    pr.cfg_val = val[CFG_DATA_W-1:0];
    plan = {plan, pr};
  endtask

  // entered and left at a falling edge
  task automatic offer_item(input sample_req_t it, input bit typed, input pick_t typed_pick);
    int gap;
    pick_t p;
    if ($urandom_range(0, 49) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {4'b0, it.frac, it.value, it.col, it.row};
    in_tuser = it.kind;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    p = predict_pick(it);
    pending_picks = {pending_picks, (typed ? typed_pick : p)};
    @(negedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid = 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_size(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                             input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls, bursts, and long hold-offs on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) rx_burst = !rx_burst;
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready = 1'b0;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        stall_left = rx_burst ? 0 : idle_len();
        out_tready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_picks.size() == 0) begin
        $error("unexpected item: status %0d data %h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = pending_picks.pop_front();
        check_field("status", TOTAL_W'(want.status), TOTAL_W'(out_tuser));
        check_field("picked_row", TOTAL_W'(want.prow), TOTAL_W'(out_tdata[3:0]));
        check_field("picked_col", TOTAL_W'(want.pcol), TOTAL_W'(out_tdata[11:4]));
        check_field("weight", TOTAL_W'(want.weight), TOTAL_W'(out_tdata[27:12]));
        check_field("total", want.total, out_tdata[63:28]);
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] phase_rows [6];
    logic [CFG_DATA_W-1:0] phase_cols [6];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_SAMPLE;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROWS;
    cfg_data = '0;
    n_rows = DEF_MAX_ROWS;
    n_cols = DEF_MAX_COLS;
    hot_row = 0;
    hot_col = 0;
    refill_table();

    table_checked(KIND_SAMPLE, 0, 0, 0, 32'd0, ST_OK, 0, 0, 100, 409600);
    table_checked(KIND_SAMPLE, 3, 9, 0, 32'hFFFF_FFFF, ST_OK, 15, 255, 100, 409600);
    table_checked(KIND_INC, 15, 255, 0, 32'd0, ST_OK, 15, 255, 101, 409601);
    table_checked(KIND_DEC, 15, 255, 0, 32'd0, ST_OK, 15, 255, 100, 409600);
    table_checked(KIND_SET, 0, 0, 0, 32'd0, ST_OK, 0, 0, 0, 409500);
    table_checked(KIND_DEC, 0, 0, 0, 32'd0, ST_REFUSED, 0, 0, 0, 409500);
    // zero weight in front is skipped
    table_checked(KIND_SAMPLE, 0, 0, 0, 32'd0, ST_OK, 0, 1, 100, 409500);
    table_checked(KIND_SET, 0, 0, 65535, 32'd0, ST_OK, 0, 0, 65535, 475035);
    table_checked(KIND_INC, 0, 0, 0, 32'd0, ST_REFUSED, 0, 0, 65535, 475035);
    table_item(KIND_SET, 0, 0, 100, 32'd0);
    table_size(CFG_ROWS, 2);
    table_checked(KIND_INC, 2, 0, 0, 32'd0, ST_RANGE, 2, 0, 0, 51200);
    table_size(CFG_COLS, 3);
    table_checked(KIND_DEC, 1, 3, 0, 32'd0, ST_RANGE, 1, 3, 0, 600);
    table_checked(KIND_SET, 15, 255, 65535, 32'd0, ST_RANGE, 15, 255, 0, 600);
    table_checked(KIND_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, ST_OK, 1, 2, 100, 600);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++) table_item(KIND_SET, r, c, 0, 32'd0);
    table_checked(KIND_SAMPLE, 5, 7, 0, 32'd0, ST_EMPTY, 0, 0, 0, 0);
    table_checked(KIND_SAMPLE, 15, 255, 65535, 32'hFFFF_FFFF, ST_EMPTY, 0, 0, 0, 0);
    table_item(KIND_SET, 1, 2, 1, 32'd0);
    table_checked(KIND_SAMPLE, 0, 0, 0, 32'hFFFF_FFFF, ST_OK, 1, 2, 1, 1);

    phase_rows = '{9'd3, 9'd0, 9'd31, 9'd16, 9'd7, CFG_DATA_W'($urandom_range(0, 511))};
    phase_cols = '{9'd5, 9'd1, 9'd511, 9'd0, 9'd256, CFG_DATA_W'($urandom_range(0, 511))};

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_size(plan[i].cfg_idx, plan[i].cfg_val);
      else offer_item(plan[i].req, plan[i].typed, plan[i].want);
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_size(CFG_ROWS, phase_rows[ph]);
      write_size(CFG_COLS, phase_cols[ph]);
      hot_row = 0;
      hot_col = 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ((ph == 0 || ph == 3) && k == 60) hold_req = 1'b1;
        offer_item(random_req(), 1'b0, '0);
      end
    end

    in_tvalid = 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/twls_pkg.sv
design/twls_ram.sv
design/twls_dp.sv
design/twls_ctrl.sv
design/two_level_weighted_sampler.sv
sim/tb_top.sv
